### hw/rtl/key_auto_repeat_scanner_assert.svh
// ----------------------------------------------------------------------------
// Key auto-repeat scanner assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_AUTO_REPEAT_SCANNER_ASSERT_SVH
`define KEY_AUTO_REPEAT_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KARS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KARS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kars_pkg.sv
// ----------------------------------------------------------------------------
// kars_pkg
// Types, constants and helpers shared by the key auto-repeat scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kars_pkg;

    localparam int KEY_W             = 9;
    localparam int EL_W              = 16;
    localparam int CFG_W             = 16;
    localparam int DEFAULT_NUM_KEYS  = 512;
    localparam int DEFAULT_TIME_BITS = 32;

    // Remainder unit retires this many dividend bits per cycle.
    localparam int DIV_BITS_PER_STEP = 4;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_DELAY    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd0;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd1;

    // HID usage codes of keys that never auto-repeat.
    localparam logic [KEY_W-1:0] SC_CAPS_LOCK  = 9'd57;
    localparam logic [KEY_W-1:0] SC_NUM_LOCK   = 9'd83;
    localparam logic [KEY_W-1:0] SC_LEFT_CTRL  = 9'd224;
    localparam logic [KEY_W-1:0] SC_RIGHT_ALT  = 9'd230;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_ADJ,
        ST_WRITE
    } kars_state_t;

    typedef struct packed {
        logic latch_in;
        logic clr_wr;
        logic rd_en;
        logic calc;
        logic div_start;
        logic adj;
        logic commit;
    } kars_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic key_ok;
        logic emit;
        logic repeat_go;
        logic div_done;
        logic out_free;
    } kars_sts_t;

    function automatic logic is_modifier(input logic [KEY_W-1:0] key);
        return (key >= SC_LEFT_CTRL && key <= SC_RIGHT_ALT)
            || key == SC_CAPS_LOCK || key == SC_NUM_LOCK;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/kars_cfg.sv
// ----------------------------------------------------------------------------
// kars_cfg
// APB register file holding the repeat delay and repeat interval.
// ----------------------------------------------------------------------------
`default_nettype none

module kars_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kars_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kars_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kars_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [kars_pkg::CFG_W-1:0]      delay,
    output logic      [kars_pkg::CFG_W-1:0]      interval
);
    import kars_pkg::*;

    logic [CFG_W-1:0] delay_reg;
    logic [CFG_W-1:0] delay_next;
    logic [CFG_W-1:0] interval_reg;
    logic [CFG_W-1:0] interval_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        delay_next    = delay_reg;
        interval_next = interval_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_DELAY:    delay_next    = pwdata[CFG_W-1:0];
                REG_INTERVAL: interval_next = pwdata[CFG_W-1:0];
                default:      delay_next    = delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            delay_reg    <= delay_next;
            interval_reg <= interval_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DELAY:    prdata = APB_DATA_W'(delay_reg);
            REG_INTERVAL: prdata = APB_DATA_W'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    assign delay    = delay_reg;
    assign interval = interval_reg;

endmodule

`default_nettype wire

### hw/rtl/kars_div.sv
// ----------------------------------------------------------------------------
// kars_div
// Multi-cycle restoring remainder unit, four dividend bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kars_div #(
    parameter int TIME_BITS = kars_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [TIME_BITS-1:0]       dividend,
    input  wire logic [kars_pkg::CFG_W-1:0] divisor,
    output logic      [kars_pkg::CFG_W-1:0] rem,
    output logic                            nz,
    output logic                            done
);
    import kars_pkg::*;

    localparam int STEPS = (TIME_BITS + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
    localparam int DIV_W = STEPS * DIV_BITS_PER_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dvd_next;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] rem_next;
    logic             nz_reg;
    logic             nz_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CFG_W-1:0] step_rem;
    logic             step_nz;

    // One radix-16 step: four dependent shift-compare-subtract stages.
    always_comb
    begin
        logic [CFG_W:0] trial;
        step_rem = rem_reg;
        step_nz  = nz_reg;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++)
        begin
            trial = {step_rem, dvd_reg[DIV_W-1-i]};
            if (trial >= {1'b0, divisor})
            begin
                trial   = trial - {1'b0, divisor};
                step_nz = 1'b1;
            end
            step_rem = trial[CFG_W-1:0];
        end
    end

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        nz_next  = nz_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = DIV_W'(dividend);
            rem_next = '0;
            nz_next  = 1'b0;
            cnt_next = CNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = dvd_reg << DIV_BITS_PER_STEP;
            rem_next = step_rem;
            nz_next  = step_nz;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        nz_reg  <= nz_next;
    end

    assign rem  = rem_reg;
    assign nz   = nz_reg;
    assign done = (cnt_reg == '0);

endmodule

`default_nettype wire

### hw/rtl/kars_dp.sv
// ----------------------------------------------------------------------------
// kars_dp
// Datapath: per-key state memory, repeat arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kars_dp #(
    parameter int NUM_KEYS  = kars_pkg::DEFAULT_NUM_KEYS,
    parameter int TIME_BITS = kars_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kars_pkg::kars_cmd_t        cmd,
    output kars_pkg::kars_sts_t             sts,
    input  wire logic [kars_pkg::CFG_W-1:0] delay,
    input  wire logic [kars_pkg::CFG_W-1:0] interval,
    input  wire logic [kars_pkg::KEY_W-1:0] key_index,
    input  wire logic                       key_down,
    input  wire logic [kars_pkg::EL_W-1:0]  elapsed_ms,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic      [kars_pkg::KEY_W-1:0] out_key,
    output logic                            out_down,
    output logic                            out_toggle
);
    import kars_pkg::*;

    localparam int IDX_W = $clog2(NUM_KEYS);
    localparam int CMP_W = (IDX_W + 1 > KEY_W) ? IDX_W + 1 : KEY_W;
    localparam int ADJ_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W + 1;
    localparam int WORD_W = TIME_BITS + 1;

    // Memory word: was_down in the top bit, held time below.
    logic [WORD_W-1:0]    mem [NUM_KEYS];
    logic [WORD_W-1:0]    rd_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [IDX_W-1:0]     clr_cnt_next;

    logic [KEY_W-1:0]     key_reg;
    logic                 down_reg;
    logic [EL_W-1:0]      el_reg;
    logic                 toggle_reg;
    logic                 toggle_next;
    logic [TIME_BITS-1:0] held_adj_reg;
    logic [TIME_BITS-1:0] held_adj_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KEY_W-1:0]     out_key_reg;
    logic                 out_down_reg;
    logic                 out_toggle_reg;

    logic [IDX_W-1:0]     key_addr;
    logic                 key_ok;
    logic                 was_down;
    logic [TIME_BITS-1:0] held_rd;
    logic [TIME_BITS-1:0] delay_ext;
    logic [TIME_BITS-1:0] excess;
    logic [CFG_W-1:0]     iv;
    logic [CFG_W-1:0]     div_rem;
    logic                 div_nz;
    logic                 div_done;
    logic [ADJ_W-1:0]     adj_sum;
    logic [TIME_BITS:0]   held_sum;
    logic [TIME_BITS-1:0] held_new;
    logic                 out_free;

    assign key_addr  = IDX_W'(key_reg);
    assign key_ok    = CMP_W'(key_reg) < CMP_W'(NUM_KEYS);
    assign was_down  = rd_reg[TIME_BITS];
    assign held_rd   = rd_reg[TIME_BITS-1:0];
    assign delay_ext = TIME_BITS'(delay);
    assign excess    = held_rd - delay_ext - TIME_BITS'(1);
    assign iv        = (interval == '0) ? CFG_W'(1) : interval;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            key_reg  <= key_index;
            down_reg <= key_down;
            el_reg   <= elapsed_ms;
        end
    end

    // Clearing pass counter.
    assign clr_cnt_next = cmd.clr_wr ? clr_cnt_reg + IDX_W'(1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Held time after the repeat step, then the saturating update.
    assign adj_sum  = ADJ_W'(delay) + ADJ_W'(div_rem) + ADJ_W'(1);
    assign held_sum = {1'b0, held_adj_reg} + (TIME_BITS + 1)'(el_reg);

    always_comb
    begin
        if (!down_reg)
        begin
            held_new = '0;
        end
        else if (held_sum[TIME_BITS])
        begin
            held_new = '1;
        end
        else
        begin
            held_new = held_sum[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            mem[key_addr] <= {down_reg, held_new};
        end
        if (cmd.rd_en && key_ok)
        begin
            rd_reg <= mem[key_addr];
        end
    end

    always_comb
    begin
        toggle_next   = toggle_reg;
        held_adj_next = held_adj_reg;
        if (cmd.calc)
        begin
            toggle_next   = down_reg && !was_down;
            held_adj_next = held_rd;
        end
        else if (cmd.adj)
        begin
            toggle_next   = toggle_reg || div_nz;
            held_adj_next = TIME_BITS'(adj_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        toggle_reg   <= toggle_next;
        held_adj_reg <= held_adj_next;
    end

    kars_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (excess),
        .divisor  (iv),
        .rem      (div_rem),
        .nz       (div_nz),
        .done     (div_done)
    );

    // Result register: frees up in the same cycle the sink takes it.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_key_reg    <= key_reg;
            out_down_reg   <= down_reg;
            out_toggle_reg <= toggle_reg;
        end
    end

    always_comb
    begin
        sts.clr_done  = (clr_cnt_reg == IDX_W'(NUM_KEYS - 1));
        sts.key_ok    = key_ok;
        sts.emit      = down_reg || was_down;
        sts.repeat_go = (delay != '0) && (held_rd > delay_ext) && !is_modifier(key_reg);
        sts.div_done  = div_done;
        sts.out_free  = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_key    = out_key_reg;
    assign out_down   = out_down_reg;
    assign out_toggle = out_toggle_reg;

endmodule

`default_nettype wire

### hw/rtl/kars_ctrl.sv
// ----------------------------------------------------------------------------
// kars_ctrl
// Controller sequencing clear, read, repeat arithmetic and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module kars_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire kars_pkg::kars_sts_t   sts,
    output kars_pkg::kars_cmd_t        cmd,
    output kars_pkg::kars_state_t      state
);
    import kars_pkg::*;

    kars_state_t state_reg;
    kars_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = sts.key_ok ? ST_CALC : ST_IDLE;
            end
            ST_CALC:
            begin
                priority if (!sts.emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.repeat_go)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_CALC:
            begin
                cmd.calc      = 1'b1;
                cmd.div_start = sts.emit && sts.repeat_go;
            end
            ST_DIV:
            begin
                cmd.calc = 1'b0;
            end
            ST_ADJ:
            begin
                cmd.adj = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

### hw/rtl/key_auto_repeat_scanner.sv
// Flow: an accepted request is latched, its key state read and the repeat check
// made; for a repeating key the remainder unit runs and the held time is adjusted.
// The result is then written back into the output register. One request is taken
// at a time; a request that reports nothing returns to idle without a write-back.
// The next request is taken once the result is in the output register, so a waiting
// result does not hold up input, though the next write-back waits until it is taken.
// Reset: asynchronous, active low; then a clearing pass zeroes every entry of the
// key state memory, during which no request is accepted.
// ----------------------------------------------------------------------------
// key_auto_repeat_scanner
// Per-key typematic auto-repeat: press edges and repeat events raise toggle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_auto_repeat_scanner_assert.svh"

module key_auto_repeat_scanner #(
    parameter int NUM_KEYS  = kars_pkg::DEFAULT_NUM_KEYS,
    parameter int TIME_BITS = kars_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kars_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kars_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kars_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    // Scan requests
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [8:0] key_index, [9] key_down, [25:10] elapsed_ms, [31:26] zero
    input  wire logic [kars_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Key reports
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [8:0] out_key, [9] out_down, [10] out_toggle, [15:11] zero
    output logic      [kars_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import kars_pkg::*;

    logic [CFG_W-1:0] delay;
    logic [CFG_W-1:0] interval;
    kars_cmd_t        cmd;
    kars_sts_t        sts;
    kars_state_t      state;
    logic [KEY_W-1:0] out_key;
    logic             out_down;
    logic             out_toggle;

    kars_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .delay    (delay),
        .interval (interval)
    );

    kars_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    kars_dp #(
        .NUM_KEYS  (NUM_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .delay      (delay),
        .interval   (interval),
        .key_index  (s_axis_tdata[KEY_W-1:0]),
        .key_down   (s_axis_tdata[KEY_W]),
        .elapsed_ms (s_axis_tdata[KEY_W+EL_W:KEY_W+1]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_key    (out_key),
        .out_down   (out_down),
        .out_toggle (out_toggle)
    );

    assign m_axis_tdata = {(M_TDATA_W - KEY_W - 2)'(0), out_toggle, out_down, out_key};

    `KARS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while another is in flight")
    `KARS_ASSERT_SAME(a_key_in_range, m_axis_tvalid, int'(m_axis_tdata[KEY_W-1:0]) < NUM_KEYS, "report for a key outside the table")
    `KARS_ASSERT_SAME(a_no_report_in_clear, state == ST_CLEAR, !m_axis_tvalid && !s_axis_tready, "activity during the clearing pass")

endmodule

`default_nettype wire
